>>> rtl/bmw_pkg.sv
// Shared types and constants for the binary morphology window block.
package bmw_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register map, one word per register.
  typedef enum logic [1:0] {
    REG_MODE        = 2'd0,
    REG_SE_HEIGHT   = 2'd1,
    REG_SE_WIDTH    = 2'd2,
    REG_IMAGE_WIDTH = 2'd3
  } bmw_reg_t;

  typedef struct packed {
    logic        mode;
    logic [3:0]  se_height;
    logic [3:0]  se_width;
    logic [10:0] image_width;
  } bmw_cfg_t;

  localparam logic        RST_MODE        = 1'b0;
  localparam logic [3:0]  RST_SE_HEIGHT   = 4'd3;
  localparam logic [3:0]  RST_SE_WIDTH    = 4'd3;
  localparam logic [10:0] RST_IMAGE_WIDTH = 11'd1024;

endpackage

>>> rtl/bmw_cfg.sv
// APB-style configuration registers for the binary morphology window block.
module bmw_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmw_pkg::ADDR_W-1:0]  paddr,
  input  logic [bmw_pkg::DATA_W-1:0]  pwdata,
  output logic [bmw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output bmw_pkg::bmw_cfg_t           cfg
);

  bmw_pkg::bmw_cfg_t cfg_r;
  bmw_pkg::bmw_reg_t reg_sel;
  logic              wr_en;

  assign reg_sel = bmw_pkg::bmw_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= bmw_pkg::RST_MODE;
      cfg_r.se_height   <= bmw_pkg::RST_SE_HEIGHT;
      cfg_r.se_width    <= bmw_pkg::RST_SE_WIDTH;
      cfg_r.image_width <= bmw_pkg::RST_IMAGE_WIDTH;
    end else if (wr_en) begin
      case (reg_sel)
        bmw_pkg::REG_MODE:        cfg_r.mode        <= pwdata[0];
        bmw_pkg::REG_SE_HEIGHT:   cfg_r.se_height   <= pwdata[3:0];
        bmw_pkg::REG_SE_WIDTH:    cfg_r.se_width    <= pwdata[3:0];
        bmw_pkg::REG_IMAGE_WIDTH: cfg_r.image_width <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      bmw_pkg::REG_MODE:        prdata = bmw_pkg::DATA_W'(cfg_r.mode);
      bmw_pkg::REG_SE_HEIGHT:   prdata = bmw_pkg::DATA_W'(cfg_r.se_height);
      bmw_pkg::REG_SE_WIDTH:    prdata = bmw_pkg::DATA_W'(cfg_r.se_width);
      bmw_pkg::REG_IMAGE_WIDTH: prdata = bmw_pkg::DATA_W'(cfg_r.image_width);
      default:                  prdata = '0;
    endcase
  end

endmodule

>>> rtl/binary_morphology_window.sv
// Top level: streaming binary erosion/dilation over a rectangular window.
//
//   channel  | handshake         | payload
//   ---------+-------------------+----------------------------------------------
//   in       | in_valid/in_ready | in_pixel_in, in_frame_start
//   out      | out_valid/out_ready| out_pixel_out, out_anchor_valid,
//            |                   | out_window_inside, out_anchor_row, out_anchor_col
//   cfg      | psel/penable/pready| paddr, pwdata, pwrite, prdata
//
// One pixel per cycle sustained while out_ready allows; each beat passes the acceptance
// register, then the output register. The rate is set by the line memory's one
// read-modify-write per column: read at acceptance, written back as the beat leaves
// that stage, forwarded when the next pixel hits the same column. Reset clears
// counters, window and pipeline valids; the line memory is not cleared. A stalled
// output holds both stages and drops in_ready only when the window stage is also full.
module binary_morphology_window #(
  parameter int MAX_SE     = 15,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_pixel_in,
  input  logic                        in_frame_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_pixel_out,
  output logic                        out_anchor_valid,
  output logic                        out_window_inside,
  output logic [11:0]                 out_anchor_row,
  output logic [9:0]                  out_anchor_col,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmw_pkg::ADDR_W-1:0]  paddr,
  input  logic [bmw_pkg::DATA_W-1:0]  pwdata,
  output logic [bmw_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  localparam int LW  = (MAX_SE > 1) ? MAX_SE - 1 : 1;
  localparam int SEW = $clog2(MAX_SE + 1);
  localparam int IW  = (MAX_SE > 1) ? $clog2(MAX_SE) : 1;
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT);

  bmw_pkg::bmw_cfg_t cfg;

  bmw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Effective sizes after clamping.
  logic [SEW-1:0] se_h, se_w, ka, ja;
  logic [WW-1:0]  wid;

  always_comb begin
    if (cfg.se_height == 4'd0)         se_h = SEW'(1);
    else if (cfg.se_height > MAX_SE)   se_h = SEW'(MAX_SE);
    else                               se_h = SEW'(cfg.se_height);
    if (cfg.se_width == 4'd0)          se_w = SEW'(1);
    else if (cfg.se_width > MAX_SE)    se_w = SEW'(MAX_SE);
    else                               se_w = SEW'(cfg.se_width);
    if (cfg.image_width == 11'd0)      wid = WW'(1);
    else if (cfg.image_width > MAX_WIDTH) wid = WW'(MAX_WIDTH);
    else                               wid = WW'(cfg.image_width);
  end

  assign ka = (se_h - SEW'(1)) >> 1;
  assign ja = (se_w - SEW'(1)) >> 1;

  // Position counters and acceptance stage.
  logic [RW-1:0] row_r, row_nxt, r0;
  logic [CW-1:0] col_r, col_nxt, c0;
  logic          in_acc, s1_fire, adv1;

  logic          s1_v_r, s1_pix_r, s1_fs_r, fwd_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;

  assign adv1     = !out_valid || out_ready;
  assign in_ready = !s1_v_r || adv1;
  assign in_acc   = in_valid && in_ready;
  assign s1_fire  = s1_v_r && adv1;

  always_comb begin
    r0 = row_r;
    c0 = col_r;
    if (in_frame_start) begin
      r0 = '0;
      c0 = '0;
    end else if (WW'(col_r) >= wid) begin
      c0 = '0;
      if (row_r < RW'(MAX_HEIGHT - 1)) r0 = row_r + RW'(1);
    end
    row_nxt = r0;
    col_nxt = c0 + CW'(1);
    if (WW'(c0) + WW'(1) >= wid) begin
      col_nxt = '0;
      if (r0 < RW'(MAX_HEIGHT - 1)) row_nxt = r0 + RW'(1);
    end
  end

  // Line memory: one word per column, bit k-1 holds row r-k.
  logic [LW-1:0] line_mem [MAX_WIDTH];
  logic [LW-1:0] rd_r, fwd_data_r, line_old, wdata;

  assign line_old = fwd_r ? fwd_data_r : rd_r;
  assign wdata    = LW'({line_old, s1_pix_r});

  always_ff @(posedge clk) begin
    if (in_acc) rd_r <= line_mem[c0];
    if (s1_fire) line_mem[s1_col_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
      fwd_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        row_r  <= row_nxt;
        col_r  <= col_nxt;
        s1_v_r <= 1'b1;
        // Forward the write-back that lands on the same column this edge.
        fwd_r  <= s1_fire && (s1_col_r == c0);
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r   <= in_pixel_in;
      s1_fs_r    <= in_frame_start;
      s1_row_r   <= r0;
      s1_col_r   <= c0;
      fwd_data_r <= wdata;
    end
  end

  // Window stage: row k, bit j is the pixel at (r-k, c-j).
  logic [MAX_SE-1:0] win_r   [MAX_SE];
  logic [MAX_SE-1:0] win_nxt [MAX_SE];
  logic [MAX_SE-1:0] col_vec;

  assign col_vec = MAX_SE'({line_old, s1_pix_r});

  always_comb begin
    for (int k = 0; k < MAX_SE; k++) begin
      win_nxt[k] = MAX_SE'({(s1_fs_r ? {MAX_SE{1'b0}} : win_r[k]), col_vec[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_SE; k++) win_r[k] <= '0;
    end else if (s1_fire) begin
      for (int k = 0; k < MAX_SE; k++) win_r[k] <= win_nxt[k];
    end
  end

  // Reduce the window and form the result.
  logic              all_one, any_one, res, is_anchor, is_inside;
  logic [MAX_SE-1:0] m;

  always_comb begin
    logic [MAX_SE-1:0] bits;
    all_one = 1'b1;
    any_one = 1'b0;
    for (int j = 0; j < MAX_SE; j++) m[j] = (j < se_w);
    for (int k = 0; k < MAX_SE; k++) begin
      bits = win_nxt[k] & m;
      if (k < se_h) begin
        if (bits != m) all_one = 1'b0;
        if (bits != '0) any_one = 1'b1;
      end
    end
  end

  assign is_anchor = (s1_row_r >= RW'(ka)) && (s1_col_r >= CW'(ja));
  assign is_inside = (s1_row_r >= RW'(se_h - SEW'(1))) &&
                     (s1_col_r >= CW'(se_w - SEW'(1)));
  assign res = is_inside ? (cfg.mode ? any_one : all_one)
                         : win_nxt[IW'(ka)][IW'(ja)];

  // Output register.
  logic        out_valid_r, pix_out_r, anc_v_r, inside_r;
  logic [11:0] anc_row_r;
  logic [9:0]  anc_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      pix_out_r <= is_anchor && res;
      anc_v_r   <= is_anchor;
      inside_r  <= is_anchor && is_inside;
      anc_row_r <= is_anchor ? 12'(s1_row_r - RW'(ka)) : 12'd0;
      anc_col_r <= is_anchor ? 10'(s1_col_r - CW'(ja)) : 10'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_out     = pix_out_r;
  assign out_anchor_valid  = anc_v_r;
  assign out_window_inside = inside_r;
  assign out_anchor_row    = anc_row_r;
  assign out_anchor_col    = anc_col_r;

`ifndef SYNTH
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !adv1 |=> s1_v_r && $stable(s1_col_r) && $stable(s1_row_r))
    else $error("window stage lost its beat under stall");

  a_acc_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted beat did not reach the window stage");

  a_no_anchor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_anchor_valid |-> !out_pixel_out && !out_window_inside &&
      out_anchor_row == 12'd0 && out_anchor_col == 10'd0)
    else $error("non-anchor result carries nonzero fields");

  a_inside_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_inside |-> out_anchor_valid)
    else $error("inside window without a valid anchor");
`endif

endmodule

>>> bench/binary_morphology_window_tb.sv
// Self-checking bench for binary_morphology_window: raster pixel streams vs. a predictor.
`timescale 1ns / 1ps

module binary_morphology_window_tb;

  localparam int SE_MAX = 15;
  localparam int W_MAX = 1024;
  localparam int H_MAX = 4096;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PIPE_SLACK = 4;
  localparam int RAND_ITEMS = 650;

  typedef struct packed {
    logic pix;
    logic fs;
  } pixel_t;

  typedef struct packed {
    logic        pix;
    logic        av;
    logic        wi;
    logic [11:0] row;
    logic [9:0]  col;
  } anchor_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_pixel_in = 1'b0;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_pixel_out;
  logic out_anchor_valid;
  logic out_window_inside;
  logic [11:0] out_anchor_row;
  logic [9:0] out_anchor_col;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bmw_pkg::ADDR_W-1:0] paddr = '0;
  logic [bmw_pkg::DATA_W-1:0] pwdata = '0;
  logic [bmw_pkg::DATA_W-1:0] prdata;
  logic pready;

  binary_morphology_window u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel_in(in_pixel_in), .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel_out(out_pixel_out), .out_anchor_valid(out_anchor_valid),
    .out_window_inside(out_window_inside),
    .out_anchor_row(out_anchor_row), .out_anchor_col(out_anchor_col),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: line history, window and raster position.
  logic line_mem [SE_MAX-1][W_MAX] = '{default: 1'b0};
  logic [SE_MAX-1:0] win_rows [SE_MAX] = '{default: '0};
  int unsigned row_cnt = 0;
  int unsigned col_cnt = 0;
  bmw_pkg::bmw_cfg_t cfg_shadow = '{bmw_pkg::RST_MODE, bmw_pkg::RST_SE_HEIGHT,
                                    bmw_pkg::RST_SE_WIDTH, bmw_pkg::RST_IMAGE_WIDTH};

  pixel_t pixel_q[$];
  anchor_t anchor_q[$];
  int unsigned fail_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  bit idle_on = 1'b1;

  function automatic int unsigned se_len(logic [3:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic int unsigned line_len(logic [10:0] v);
    if (v == 0) return 1;
    if (v > W_MAX) return W_MAX;
    return v;
  endfunction

  task automatic erode_dilate_step(input logic pix, input logic fs, output anchor_t res);
    int unsigned h, w, wid, r, c, ka, ja, k;
    logic [SE_MAX-1:0] colv, m, bits;
    logic all_one, any_one;
    h = se_len(cfg_shadow.se_height);
    w = se_len(cfg_shadow.se_width);
    wid = line_len(cfg_shadow.image_width);
    if (fs) begin
      row_cnt = 0;
      col_cnt = 0;
      for (k = 0; k < SE_MAX; k++) win_rows[k] = '0;
    end else if (col_cnt >= wid) begin
      // width was lowered under a row in progress: wrap now
      col_cnt = 0;
      if (row_cnt < H_MAX - 1) row_cnt++;
    end
    r = row_cnt;
    c = col_cnt;
    colv[0] = pix;
    for (k = 1; k < SE_MAX; k++) colv[k] = line_mem[k-1][c];
    for (k = SE_MAX - 1; k >= 2; k--) line_mem[k-1][c] = line_mem[k-2][c];
    line_mem[0][c] = pix;
    for (k = 0; k < SE_MAX; k++) win_rows[k] = {win_rows[k][SE_MAX-2:0], colv[k]};
    ka = (h - 1) - h / 2;
    ja = (w - 1) - w / 2;
    res = '0;
    if (r >= ka && c >= ja) begin
      res.wi = (r >= h - 1) && (c >= w - 1);
      if (res.wi) begin
        m = {SE_MAX{1'b1}} >> (SE_MAX - w);
        all_one = 1'b1;
        any_one = 1'b0;
        for (k = 0; k < h; k++) begin
          bits = win_rows[k] & m;
          if (bits != m) all_one = 1'b0;
          if (bits != 0) any_one = 1'b1;
        end
        res.pix = cfg_shadow.mode ? any_one : all_one;
      end else begin
        res.pix = win_rows[ka][ja];
      end
      res.av = 1'b1;
      res.row = 12'(r - ka);
      res.col = 10'(c - ja);
    end
    if (c + 1 >= wid) begin
      col_cnt = 0;
      if (row_cnt < H_MAX - 1) row_cnt++;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] pick_se();
    case ($urandom_range(0, 9))
      0: return 4'd0;
      1: return 4'd1;
      2: return 4'd15;
      3: return 4'd2;
      default: return 4'($urandom_range(1, 15));
    endcase
  endfunction

  function automatic logic [10:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd2;
      default: return 11'($urandom_range(3, 20));
    endcase
  endfunction

  function automatic void queue_pixel(logic pix, logic fs);
    pixel_t p;
    p.pix = pix;
    p.fs = fs;
    pixel_q.push_back(p);
  endfunction

  // Noisy runs carry the odd stray frame start.
  function automatic void push_run(int unsigned count, bit fs_first, bit noisy);
    int unsigned dens, i;
    case ($urandom_range(0, 5))
      0: dens = 0;
      1: dens = 100;
      2: dens = 10;
      3: dens = 90;
      default: dens = 50;
    endcase
    for (i = 0; i < count; i++)
      queue_pixel($urandom_range(0, 99) < dens,
                  (i == 0) ? fs_first : (noisy && $urandom_range(0, 79) == 0));
  endfunction

  // Hold until the block is empty, then give the pipeline a few more cycles.
  task automatic drain();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_valid || anchor_q.size() != 0);
    repeat (PIPE_SLACK) @(negedge clk);
  endtask

  // Write one register, read it back, and track it in the predictor.
  task automatic cfg_access(input bmw_pkg::bmw_reg_t idx, input int unsigned val);
    logic [bmw_pkg::DATA_W-1:0] mask, wr;
    case (idx)
      bmw_pkg::REG_MODE: mask = 32'h1;
      bmw_pkg::REG_SE_HEIGHT, bmw_pkg::REG_SE_WIDTH: mask = 32'hF;
      default: mask = 32'h7FF;
    endcase
    wr = ($urandom() & ~mask) | (val & mask);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= wr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== (wr & mask)) begin
      $display("%0t: register %s read back, expected %0h, actual %0h",
               $time, idx.name(), wr & mask, prdata);
      fail_cnt++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      bmw_pkg::REG_MODE: cfg_shadow.mode = wr[0];
      bmw_pkg::REG_SE_HEIGHT: cfg_shadow.se_height = wr[3:0];
      bmw_pkg::REG_SE_WIDTH: cfg_shadow.se_width = wr[3:0];
      default: cfg_shadow.image_width = wr[10:0];
    endcase
    @(negedge clk);
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    fail_cnt++;
  endtask

  // Driver: predict on each accepted beat, then load the next one after its gap.
  always @(posedge clk) begin : drive
    pixel_t nxt;
    anchor_t predicted;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        erode_dilate_step(in_pixel_in, in_frame_start, predicted);
        anchor_q.push_back(predicted);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pixel_q.size() != 0) begin
          nxt = pixel_q.pop_front();
          in_valid <= 1'b1;
          in_pixel_in <= nxt.pix;
          in_frame_start <= nxt.fs;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin : watch
    anchor_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (anchor_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual row %0d col %0d",
                   $time, out_anchor_row, out_anchor_col);
          fail_cnt++;
        end else begin
          want = anchor_q.pop_front();
          if (out_pixel_out !== want.pix) flag_mismatch("pixel_out", want.pix, out_pixel_out);
          if (out_anchor_valid !== want.av)
            flag_mismatch("anchor_valid", want.av, out_anchor_valid);
          if (out_window_inside !== want.wi)
            flag_mismatch("window_inside", want.wi, out_window_inside);
          if (out_anchor_row !== want.row)
            flag_mismatch("anchor_row", want.row, out_anchor_row);
          if (out_anchor_col !== want.col)
            flag_mismatch("anchor_col", want.col, out_anchor_col);
        end
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned i, rand_items, rows, wid, count;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: first row only, so no beat has a valid anchor.
    for (i = 0; i < 6; i++) queue_pixel(i[0], 1'b0);
    drain();
    cfg_access(bmw_pkg::REG_MODE, 0);
    cfg_access(bmw_pkg::REG_SE_HEIGHT, 3);
    cfg_access(bmw_pkg::REG_SE_WIDTH, 3);
    cfg_access(bmw_pkg::REG_IMAGE_WIDTH, 4);
    // 4x4 of ones with the last pixel cleared, then a short restarted frame
    for (i = 0; i < 16; i++) queue_pixel(i != 15, i == 0);
    queue_pixel(1'b1, 1'b1);
    queue_pixel(1'b0, 1'b0);
    queue_pixel(1'b1, 1'b0);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      drain();
      idle_on = ($urandom_range(0, 4) != 0);
      cfg_access(bmw_pkg::REG_MODE, $urandom_range(0, 1));
      cfg_access(bmw_pkg::REG_SE_HEIGHT, pick_se());
      cfg_access(bmw_pkg::REG_SE_WIDTH, pick_se());
      cfg_access(bmw_pkg::REG_IMAGE_WIDTH, pick_width());
      wid = line_len(cfg_shadow.image_width);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0) drain();
        rows = se_len(cfg_shadow.se_height) + $urandom_range(0, 3);
        count = wid * rows;
        if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
        if (count > RAND_ITEMS - rand_items) count = RAND_ITEMS - rand_items;
        push_run(count, 1'b1, 1'b1);
        rand_items += count;
      end
    end

    // Lower the width while the column counter sits past the new width.
    drain();
    idle_on = 1'b1;
    cfg_access(bmw_pkg::REG_SE_HEIGHT, 3);
    cfg_access(bmw_pkg::REG_SE_WIDTH, 3);
    cfg_access(bmw_pkg::REG_IMAGE_WIDTH, 8);
    push_run(22, 1'b1, 1'b0);
    drain();
    cfg_access(bmw_pkg::REG_IMAGE_WIDTH, 5);
    push_run(15, 1'b0, 1'b0);

    // Oversized width saturates to the full line: a partial first row.
    drain();
    idle_on = ($urandom_range(0, 1) != 0);
    cfg_access(bmw_pkg::REG_MODE, $urandom_range(0, 1));
    cfg_access(bmw_pkg::REG_SE_WIDTH, 15);
    cfg_access(bmw_pkg::REG_IMAGE_WIDTH, 2047);
    push_run(60, 1'b1, 1'b0);

    // Zero width and a tall element: one column, every pixel its own row.
    drain();
    idle_on = 1'b0;
    cfg_access(bmw_pkg::REG_MODE, 1);
    cfg_access(bmw_pkg::REG_SE_HEIGHT, 15);
    cfg_access(bmw_pkg::REG_SE_WIDTH, 1);
    cfg_access(bmw_pkg::REG_IMAGE_WIDTH, 0);
    push_run(2 * SE_MAX, 1'b1, 1'b0);

    drain();
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && anchor_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bmw_pkg.sv
rtl/bmw_cfg.sv
rtl/binary_morphology_window.sv
bench/binary_morphology_window_tb.sv
